[rtl/core/etrig_pkg.sv]
// Shared types and constants for the scope edge trigger search unit.
// Used by etrig_seq and scope_edge_trigger_search_unit; no dependencies.
`default_nettype none

package etrig_pkg;

  localparam int LEVEL_W    = 12;
  localparam int OFFSET_W   = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_LEVEL     = 1'b0,
    CFG_PRETRIGGER_OFFSET = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_STORE  = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  localparam logic [LEVEL_W-1:0]  LEVEL_RST  = 12'd2048;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 10'd64;

endpackage

`default_nettype wire

[rtl/core/etrig_ring.sv]
// Sample ring buffer: single write port, one registered read port.
// Entries beyond the write fill count read as zero; no package dependency.
`default_nettype none

module etrig_ring #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int FILL_W = IDX_W + 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_raw_r;
  logic              rd_vld_r;
  logic [FILL_W-1:0] fill_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_r <= mem[rd_addr];
      rd_vld_r <= ({1'b0, rd_addr} < fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (wr_en && (fill_r != FILL_MAX)) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

`default_nettype wire

[rtl/core/etrig_seq.sv]
// Command sequencer: sample stores, newest index, and the backward edge walk
// with a >= and a < comparison against the level. Depends on etrig_pkg.
`default_nettype none

module etrig_seq
  import etrig_pkg::*;
#(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic                     in_cmd,
  input  wire logic [DATA_W-1:0]        in_sample_value,
  input  wire logic [LEVEL_W-1:0]       level,
  input  wire logic [OFFSET_W-1:0]      offset,
  output logic                          busy,
  output logic                          wr_en,
  output logic      [$clog2(DEPTH)-1:0] wr_addr,
  output logic      [DATA_W-1:0]        wr_data,
  output logic                          rd_en,
  output logic      [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic [DATA_W-1:0]        rd_data,
  output logic                          out_strobe,
  output logic      [$clog2(DEPTH)-1:0] out_trigger_index,
  output logic                          out_found
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (DATA_W > LEVEL_W) ? DATA_W : LEVEL_W;
  localparam int EXT_W = IDX_W + OFFSET_W;
  localparam logic [IDX_W-1:0] HALF = IDX_W'(DEPTH / 2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_WALK
  } state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  newest_r;
  logic [IDX_W-1:0]  addr_r;
  logic [IDX_W-1:0]  start_r;
  logic [IDX_W-1:0]  cur_pos_r;
  logic [DATA_W-1:0] prev_r;
  logic [IDX_W-1:0]  cnt_r;
  logic              strobe_r;
  logic [IDX_W-1:0]  idx_r;
  logic              found_r;

  logic              accept;
  logic [EXT_W-1:0]  ofs_ext;
  logic [IDX_W-1:0]  start_pos;
  logic [CMP_W-1:0]  lvl_cmp;
  logic              cur_ge;
  logic              old_lt;
  logic              hit;
  logic              last;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign wr_en     = accept && (in_cmd == CMD_STORE);
  assign wr_addr   = newest_r + 1'b1;
  assign wr_data   = in_sample_value;
  assign ofs_ext   = EXT_W'(offset);
  assign start_pos = newest_r - ofs_ext[IDX_W-1:0];
  assign rd_en     = (state_r != S_IDLE);
  assign rd_addr   = addr_r;

  assign lvl_cmp = CMP_W'(level);
  assign cur_ge  = CMP_W'(prev_r) >= lvl_cmp;
  assign old_lt  = CMP_W'(rd_data) < lvl_cmp;
  assign hit     = (cnt_r != '0) && cur_ge && old_lt;
  assign last    = (cnt_r == HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      newest_r <= '1;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_cmd == CMD_STORE) begin
              newest_r <= wr_addr;
            end else begin
              addr_r  <= start_pos;
              start_r <= start_pos;
              state_r <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          addr_r  <= addr_r - 1'b1;
          cnt_r   <= '0;
          state_r <= S_WALK;
        end
        S_WALK: begin
          addr_r    <= addr_r - 1'b1;
          prev_r    <= rd_data;
          cur_pos_r <= addr_r + 1'b1;
          cnt_r     <= cnt_r + 1'b1;
          if (hit) begin
            strobe_r <= 1'b1;
            idx_r    <= cur_pos_r;
            found_r  <= 1'b1;
            state_r  <= S_IDLE;
          end else if (last) begin
            strobe_r <= 1'b1;
            idx_r    <= start_r;
            found_r  <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe        = strobe_r;
  assign out_trigger_index = idx_r;
  assign out_found         = found_r;

endmodule

`default_nettype wire

[rtl/core/scope_edge_trigger_search_unit.sv]
// Scope edge trigger search unit, top level: configuration registers,
// sequencer and sample ring. Depends on etrig_pkg, etrig_seq, etrig_ring.
//
// A store command (in_cmd = 0) is taken while busy is low and leaves busy
// low, so stores may arrive on every clock outside a search. A search
// command (in_cmd = 1) raises busy and walks back from the newest sample
// minus the pretrigger offset, one ring entry per cycle through the single
// read port of the ring buffer. The walk stops early when an edge is found;
// when it ends, the result appears on out_trigger_index and out_found for
// exactly one cycle with out_strobe high, and busy drops in that same cycle.
// The receiver cannot hold the result off and must capture it on that strobe.
// BUFFER_DEPTH must be a power of two. Ring entries never written read as
// zero, with no clearing pass after reset. Write configuration only while
// busy is low.
`default_nettype none

module scope_edge_trigger_search_unit
  import etrig_pkg::*;
#(
  parameter int BUFFER_DEPTH = 2048,
  parameter int SAMPLE_BITS  = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_cmd,
  input  wire logic [SAMPLE_BITS-1:0]          in_sample_value,
  output logic                                 out_strobe,
  output logic      [$clog2(BUFFER_DEPTH)-1:0] out_trigger_index,
  output logic                                 out_found,
  input  wire logic                            cfg_we,
  input  wire logic [CFG_IDX_W-1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0]           cfg_wdata
);

  localparam int IDX_W = $clog2(BUFFER_DEPTH);

  logic [LEVEL_W-1:0]     level_r;
  logic [OFFSET_W-1:0]    offset_r;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= LEVEL_RST;
      offset_r <= OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TRIGGER_LEVEL:     level_r  <= cfg_wdata[LEVEL_W-1:0];
        CFG_PRETRIGGER_OFFSET: offset_r <= cfg_wdata[OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  etrig_seq #(
    .DEPTH  (BUFFER_DEPTH),
    .DATA_W (SAMPLE_BITS)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_cmd            (in_cmd),
    .in_sample_value   (in_sample_value),
    .level             (level_r),
    .offset            (offset_r),
    .busy              (busy),
    .wr_en             (wr_en),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_strobe        (out_strobe),
    .out_trigger_index (out_trigger_index),
    .out_found         (out_found)
  );

  etrig_ring #(
    .DEPTH  (BUFFER_DEPTH),
    .DATA_W (SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
